### rtl/core/touch_wheel_quadrant_decoder_top_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the touch wheel quadrant decoder
// Shared checks on clk, switched off while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef TOUCH_WHEEL_QUADRANT_DECODER_TOP_ASSERT_SVH
`define TOUCH_WHEEL_QUADRANT_DECODER_TOP_ASSERT_SVH

// Same-cycle implication
`define TWQD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define TWQD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/twqd_pkg.sv
// ---------------------------------------------------------------------------
// twqd_pkg
// Types and fixed constants of the touch wheel quadrant decoder.
// ---------------------------------------------------------------------------
package twqd_pkg;

    // Coordinate width of the touchpad samples and of the wheel centre
    localparam int COORD_BITS  = 12;
    localparam int FINGER_BITS = 3;
    localparam int SEL_BITS    = 4;
    localparam int RANGE_BITS  = 12;
    localparam int CFG_IDX_BITS = 2;

    // Stream payload widths, rounded up to whole bytes
    localparam int IN_DATA_BITS  = 32;
    localparam int OUT_DATA_BITS = 40;

    typedef logic [COORD_BITS-1:0] coord_t;
    typedef logic [RANGE_BITS-1:0] range_t;

    // Quadrant codes as reported on the result
    typedef enum logic [2:0] {
        QUAD_INVALID      = 3'd0,
        QUAD_TOP_RIGHT    = 3'd1,
        QUAD_BOTTOM_RIGHT = 3'd2,
        QUAD_BOTTOM_LEFT  = 3'd3,
        QUAD_TOP_LEFT     = 3'd4
    } quad_t;

    // Rotation codes, two's complement
    typedef logic signed [1:0] rot_t;
    localparam rot_t ROT_NONE = 2'sb00;
    localparam rot_t ROT_CW   = 2'sb01;
    localparam rot_t ROT_CCW  = 2'sb11;

    // Configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_RANGE_X = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_RANGE_Y = 2'd1;

    // Reset value of both range registers
    localparam range_t RANGE_RESET = 12'd4095;

    localparam logic [FINGER_BITS-1:0] ONE_FINGER = 3'd1;

endpackage

### rtl/core/touch_wheel_quadrant_decoder_top.sv
// Path: an input transfer is held in the input register, then in the result register on the master side.
// Throughput: one sample per cycle while results are taken; an input register feeds one pass of
// compare, reciprocal-multiply and add logic into the result/state register.
// The input register still takes one sample while a finished result waits downstream.
// Reset (rst_n low, asynchronous): both stages empty, ranges 4095, centre
// 2047/2047, last quadrant invalid, item index zero.
// ---------------------------------------------------------------------------
// touch_wheel_quadrant_decoder_top
// Tracks a one-finger touch around a drifting wheel centre, reports the
// quadrant and steps a selected item index on clockwise or counter-clockwise
// quadrant changes.
// ---------------------------------------------------------------------------
module touch_wheel_quadrant_decoder_top
    import twqd_pkg::*;
#(
    parameter int ITEM_COUNT    = 10,
    parameter int DRIFT_DIVISOR = 30
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    // Configuration write port
    input  logic                     cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [RANGE_BITS-1:0]    cfg_data,
    // Sample stream
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    // [11:0] touch_x, [23:12] touch_y, [26:24] finger_count, [31:27] zero
    input  logic [IN_DATA_BITS-1:0]  s_axis_tdata,
    // Result stream
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    // [3:0] selected_item, [6:4] quadrant, [8:7] rotation,
    // [20:9] wheel_center_x, [32:21] wheel_center_y, [39:33] zero
    output logic [OUT_DATA_BITS-1:0] m_axis_tdata
);

`include "touch_wheel_quadrant_decoder_top_assert.svh"

    // Index sizing
    localparam int IDX_BITS = $clog2(ITEM_COUNT);
    localparam logic [IDX_BITS:0]   COUNT_W  = (IDX_BITS+1)'(ITEM_COUNT);
    localparam logic [IDX_BITS-1:0] IDX_LAST = IDX_BITS'(ITEM_COUNT - 1);

    // Reciprocal for the drift division, exact for all magnitudes below 2^COORD_BITS
    localparam int DIV_LOG   = $clog2(DRIFT_DIVISOR);
    localparam int SHIFT     = COORD_BITS + DIV_LOG;
    localparam int MULT_BITS = COORD_BITS + 1;
    localparam int PROD_BITS = COORD_BITS + MULT_BITS;
    localparam logic [MULT_BITS-1:0] RECIP =
        MULT_BITS'(((longint'(1) << SHIFT) + DRIFT_DIVISOR - 1) / DRIFT_DIVISOR);

    // Configuration registers
    range_t range_x_reg;
    range_t range_y_reg;

    // Input stage
    logic                    in_valid_reg;
    coord_t                  touch_x_reg;
    coord_t                  touch_y_reg;
    logic [FINGER_BITS-1:0]  finger_reg;

    // Result stage, which is also the tracking state
    logic                 out_valid_reg;
    coord_t               center_x_reg, center_x_next;
    coord_t               center_y_reg, center_y_next;
    quad_t                quad_reg, quad_next;
    rot_t                 rot_reg, rot_next;
    logic [IDX_BITS-1:0]  idx_reg, idx_next;

    logic                 out_free;
    logic                 fire;
    logic                 right, top;
    logic [IDX_BITS:0]    idx_inc;
    logic [IDX_BITS+SEL_BITS-1:0] idx_ext;

    // Move a centre coordinate by offset / DRIFT_DIVISOR, truncated toward zero
    function automatic coord_t drift(input coord_t center, input coord_t sample);
        logic signed [COORD_BITS:0] offset;
        logic [COORD_BITS-1:0]      mag;
        logic [PROD_BITS-1:0]       prod;
        logic [PROD_BITS-1:0]       shifted;
        logic [COORD_BITS-1:0]      quo;
        logic signed [COORD_BITS:0] delta;
        logic [COORD_BITS:0]        moved;
        offset  = $signed({1'b0, sample}) - $signed({1'b0, center});
        mag     = offset[COORD_BITS] ? COORD_BITS'(-offset) : offset[COORD_BITS-1:0];
        prod    = PROD_BITS'(mag) * PROD_BITS'(RECIP);
        shifted = prod >> SHIFT;
        quo     = shifted[COORD_BITS-1:0];
        delta   = offset[COORD_BITS] ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
        moved   = {1'b0, center} + $unsigned(delta);
        return moved[COORD_BITS-1:0];
    endfunction

    // Handshake: the result stage advances when its register is empty or taken
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign fire          = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || out_free;
    assign m_axis_tvalid = out_valid_reg;

    // Write configuration; other indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_x_reg <= RANGE_RESET;
            range_y_reg <= RANGE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_RANGE_X: range_x_reg <= cfg_data;
                REG_RANGE_Y: range_y_reg <= cfg_data;
                default:     ;
            endcase
        end
    end

    // Input stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    // Input stage payload
    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            touch_x_reg <= s_axis_tdata[COORD_BITS-1:0];
            touch_y_reg <= s_axis_tdata[2*COORD_BITS-1:COORD_BITS];
            finger_reg  <= s_axis_tdata[2*COORD_BITS+FINGER_BITS-1:2*COORD_BITS];
        end
    end

    // Quadrant and centre update
    always_comb
    begin
        right = touch_x_reg >= center_x_reg;
        top   = touch_y_reg >= center_y_reg;
        if (finger_reg != ONE_FINGER)
        begin
            quad_next     = QUAD_INVALID;
            center_x_next = COORD_BITS'(range_x_reg >> 1);
            center_y_next = COORD_BITS'(range_y_reg >> 1);
        end
        else
        begin
            if (right)
                quad_next = top ? QUAD_TOP_RIGHT : QUAD_BOTTOM_RIGHT;
            else
                quad_next = top ? QUAD_TOP_LEFT : QUAD_BOTTOM_LEFT;
            center_x_next = drift(center_x_reg, touch_x_reg);
            center_y_next = drift(center_y_reg, touch_y_reg);
        end
    end

    // Rotation between two valid quadrants
    always_comb
    begin
        if ((quad_reg == QUAD_TOP_RIGHT    && quad_next == QUAD_BOTTOM_RIGHT) ||
            (quad_reg == QUAD_BOTTOM_RIGHT && quad_next == QUAD_BOTTOM_LEFT)  ||
            (quad_reg == QUAD_BOTTOM_LEFT  && quad_next == QUAD_TOP_LEFT)     ||
            (quad_reg == QUAD_TOP_LEFT     && quad_next == QUAD_TOP_RIGHT))
            rot_next = ROT_CW;
        else if ((quad_reg == QUAD_TOP_RIGHT    && quad_next == QUAD_TOP_LEFT)     ||
                 (quad_reg == QUAD_BOTTOM_RIGHT && quad_next == QUAD_TOP_RIGHT)    ||
                 (quad_reg == QUAD_BOTTOM_LEFT  && quad_next == QUAD_BOTTOM_RIGHT) ||
                 (quad_reg == QUAD_TOP_LEFT     && quad_next == QUAD_BOTTOM_LEFT))
            rot_next = ROT_CCW;
        else
            rot_next = ROT_NONE;
    end

    // Step the item index, wrapping within the item count
    always_comb
    begin
        idx_inc  = {1'b0, idx_reg} + 1'b1;
        idx_next = idx_reg;
        if (rot_next == ROT_CW)
            idx_next = (idx_inc >= COUNT_W) ? '0 : idx_inc[IDX_BITS-1:0];
        else if (rot_next == ROT_CCW)
            idx_next = (idx_reg == '0 || {1'b0, idx_reg} >= COUNT_W) ?
                       IDX_LAST : idx_reg - 1'b1;
    end

    // Result and tracking state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            center_x_reg  <= COORD_BITS'(RANGE_RESET >> 1);
            center_y_reg  <= COORD_BITS'(RANGE_RESET >> 1);
            quad_reg      <= QUAD_INVALID;
            rot_reg       <= ROT_NONE;
            idx_reg       <= '0;
        end
        else
        begin
            if (out_free)
                out_valid_reg <= in_valid_reg;
            if (fire)
            begin
                center_x_reg <= center_x_next;
                center_y_reg <= center_y_next;
                quad_reg     <= quad_next;
                rot_reg      <= rot_next;
                idx_reg      <= idx_next;
            end
        end
    end

    // Pack the result
    assign idx_ext = {{SEL_BITS{1'b0}}, idx_reg};
    assign m_axis_tdata = {
        (OUT_DATA_BITS - SEL_BITS - 3 - 2 - 2*COORD_BITS)'(0),
        center_y_reg,
        center_x_reg,
        rot_reg,
        quad_reg,
        idx_ext[SEL_BITS-1:0]
    };

    // Checks
    `TWQD_ASSERT_NOW(a_rot_needs_valid_quad,
        out_valid_reg && rot_reg != ROT_NONE, quad_reg != QUAD_INVALID,
        "rotation reported with an invalid quadrant")
    `TWQD_ASSERT_NOW(a_idx_in_range, 1'b1, {1'b0, idx_reg} < COUNT_W,
        "item index beyond item count")
    `TWQD_ASSERT_NEXT(a_idx_holds_without_rot, fire && rot_next == ROT_NONE,
        $stable(idx_reg), "item index moved without a rotation")
    `TWQD_ASSERT_NOW(a_stall_blocks_input,
        in_valid_reg && out_valid_reg && !m_axis_tready, !s_axis_tready,
        "input taken while both stages are full and stalled")

endmodule
